// ===== rtl/motor_speed_ramp_reverser_defines.svh =====
// Assertion macros for the motor speed ramp reverser.
// Used by the top level only; depends on nothing.
`ifndef MOTOR_SPEED_RAMP_REVERSER_DEFINES_SVH
`define MOTOR_SPEED_RAMP_REVERSER_DEFINES_SVH

// same-cycle implication
`define MSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msr: implication check failed");

// next-cycle implication
`define MSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msr: next-cycle check failed");

`endif

// ===== rtl/msr_pkg.sv =====
// Shared types and constants for the motor speed ramp reverser.
// No dependencies.
package msr_pkg;

    localparam int unsigned SPEED_W   = 7;
    localparam int unsigned CMD_W     = 8;
    localparam int unsigned DUTY_W    = 10;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd100;
    localparam logic [SPEED_W-1:0] STEP_RESET = 7'd5;
    // floor(x * 10.2) == (x * DUTY_RECIP) >> 16 for x in 0..127
    localparam logic [19:0] DUTY_RECIP = 20'd668508;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SPEED = 2'd1,
        FUNC_DIR   = 2'd2
    } func_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [CMD_W-1:0] speed_command;
        logic             forward_command;
    } item_t;

    typedef struct packed {
        logic [SPEED_W-1:0] cur;
        logic [SPEED_W-1:0] tgt;
        logic               fwd;
        logic               pending;
        logic [SPEED_W-1:0] saved;
    } state_t;

    typedef struct packed {
        logic               rejected;
        logic               going_forward;
        logic               ramping;
        logic [SPEED_W-1:0] speed_now;
        logic [DUTY_W-1:0]  duty_reverse;
        logic [DUTY_W-1:0]  duty_forward;
    } result_t;

endpackage

// ===== rtl/msr_cfg_reg.sv =====
// Ramp step register with range check on write.
// Depends on msr_pkg.
module msr_cfg_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [msr_pkg::SPEED_W-1:0]   wr_data,
    output logic [msr_pkg::SPEED_W-1:0]   step
);

    logic [msr_pkg::SPEED_W-1:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= msr_pkg::STEP_RESET;
        end
        else if (wr_en && (wr_data <= msr_pkg::SPEED_MAX))
        begin
            step_reg <= wr_data;
        end
    end

    assign step = step_reg;

endmodule

// ===== rtl/msr_step_logic.sv =====
// Per-item state update and result formation (combinational).
// Depends on msr_pkg.
module msr_step_logic (
    input  msr_pkg::item_t                item,
    input  logic [msr_pkg::SPEED_W-1:0]   step,
    input  msr_pkg::state_t               st,
    output msr_pkg::state_t               st_next,
    output msr_pkg::result_t              res
);

    logic [msr_pkg::SPEED_W:0]   cur_up;
    logic [msr_pkg::SPEED_W:0]   tgt_up;
    logic [msr_pkg::SPEED_W-1:0] cur_tick;
    logic                        rej;
    logic [26:0]                 prod;
    logic [msr_pkg::DUTY_W-1:0]  duty;

    assign cur_up = {1'b0, st.cur} + {1'b0, step};
    assign tgt_up = {1'b0, st.tgt} + {1'b0, step};

    always_comb
    begin
        cur_tick = st.cur;
        if (st.cur < st.tgt)
        begin
            cur_tick = (cur_up >= {1'b0, st.tgt}) ? st.tgt : cur_up[msr_pkg::SPEED_W-1:0];
        end
        else if (st.cur > st.tgt)
        begin
            cur_tick = ({1'b0, st.cur} <= tgt_up) ? st.tgt : (st.cur - step);
        end
    end

    always_comb
    begin
        st_next = st;
        rej     = 1'b0;
        unique case (item.func)
            msr_pkg::FUNC_TICK:
            begin
                st_next.cur = cur_tick;
                if (st.pending && (cur_tick == '0) && (st.tgt == '0))
                begin
                    st_next.fwd     = ~st.fwd;
                    st_next.tgt     = st.saved;
                    st_next.pending = 1'b0;
                end
            end
            msr_pkg::FUNC_SPEED:
            begin
                if (item.speed_command > {1'b0, msr_pkg::SPEED_MAX})
                begin
                    rej = 1'b1;
                end
                else if (st.pending)
                begin
                    st_next.saved = item.speed_command[msr_pkg::SPEED_W-1:0];
                end
                else
                begin
                    st_next.tgt = item.speed_command[msr_pkg::SPEED_W-1:0];
                end
            end
            msr_pkg::FUNC_DIR:
            begin
                if (!st.pending && (item.forward_command != st.fwd))
                begin
                    if ((st.cur == '0) && (st.tgt == '0))
                    begin
                        st_next.fwd = item.forward_command;
                    end
                    else
                    begin
                        st_next.saved   = st.tgt;
                        st_next.tgt     = '0;
                        st_next.pending = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    assign prod = 27'(st_next.cur) * 27'(msr_pkg::DUTY_RECIP);
    assign duty = prod[25:16];

    always_comb
    begin
        res.rejected      = rej;
        res.going_forward = st_next.fwd;
        res.ramping       = (st_next.cur != st_next.tgt);
        res.speed_now     = st_next.cur;
        res.duty_forward  = st_next.fwd ? duty : '0;
        res.duty_reverse  = st_next.fwd ? '0 : duty;
    end

endmodule

// ===== rtl/motor_speed_ramp_reverser.sv =====
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tuser func, s_tdata command fields
// m_*       out  m_tvalid / m_tready    m_tdata duty values and status
// cfg_*     in   cfg_valid / cfg_ready  cfg_data ramp step
//
// One item per cycle sustained while m_tready is high; the result passes through the input
// register, then the state update into the result register.
// Reset: rst_n async low; speed 0, target 0, forward, step 5.
// Stalls on m_tready hold the result register; the input register still takes one item.
// cfg_ready is always high. Depends on msr_pkg, msr_cfg_reg, msr_step_logic, defines header.
`include "motor_speed_ramp_reverser_defines.svh"

module motor_speed_ramp_reverser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] speed_command, [8] forward_command, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] duty_forward, [19:10] duty_reverse,
                                   // [26:20] speed_now, [27] ramping,
                                   // [28] going_forward, [29] rejected, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    msr_pkg::item_t              in_item_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    msr_pkg::result_t            out_res_reg;
    msr_pkg::state_t             state_reg;
    msr_pkg::state_t             state_next;
    msr_pkg::result_t            res;
    msr_pkg::item_t              s_item;
    logic [msr_pkg::SPEED_W-1:0] step;
    logic                        advance;
    logic                        fire;
    logic                        in_acc;

    assign cfg_ready = 1'b1;

    assign s_item.func            = s_tuser;
    assign s_item.speed_command   = s_tdata[7:0];
    assign s_item.forward_command = s_tdata[8];

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_acc   = s_tvalid && s_tready;

    assign in_valid_next  = in_acc ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    msr_cfg_reg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_data (cfg_data),
        .step    (step)
    );

    msr_step_logic u_step (
        .item    (in_item_reg),
        .step    (step),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg.cur     <= '0;
            state_reg.tgt     <= '0;
            state_reg.fwd     <= 1'b1;
            state_reg.pending <= 1'b0;
            state_reg.saved   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_item_reg <= s_item;
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

    `MSR_ASSERT_IMP(a_pending_tgt_zero, clk, rst_n, state_reg.pending, state_reg.tgt == '0)
    `MSR_ASSERT_IMP(a_one_side_driven, clk, rst_n, m_tvalid,
        (m_tdata[9:0] == 10'd0) || (m_tdata[19:10] == 10'd0))
    `MSR_ASSERT_IMP(a_speed_range, clk, rst_n, 1'b1,
        (state_reg.cur <= msr_pkg::SPEED_MAX) && (step <= msr_pkg::SPEED_MAX))
    `MSR_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_valid && (cfg_data <= msr_pkg::SPEED_MAX),
        step == $past(cfg_data))

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for motor_speed_ramp_reverser: directed rows, then random phases.
// Results are checked field by field against known row values or a local ramp and reversal model.
// Depends on msr_pkg and the motor_speed_ramp_reverser RTL.
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam msr_pkg::result_t NO_STATUS = '0;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [1:0]       f;
        logic [7:0]       value;
        logic             fw;
        bit               known;
        msr_pkg::result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    // model state
    int unsigned ramp_step_now;
    int unsigned motor_cur;
    int unsigned motor_tgt;
    int unsigned motor_saved;
    bit          motor_fwd;
    bit          reversal_wait;

    msr_pkg::result_t expected_status_q [$];
    int               mismatch_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               idle_levels [4] = '{0, 10, 30, 60};
    stim_row_t        directed_rows [30];

    motor_speed_ramp_reverser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic msr_pkg::result_t motor_status(int df, int dr, int spd, bit ramp,
                                                      bit fwd, bit rej);
        msr_pkg::result_t r;
        r.duty_forward  = 10'(df);
        r.duty_reverse  = 10'(dr);
        r.speed_now     = 7'(spd);
        r.ramping       = ramp;
        r.going_forward = fwd;
        r.rejected      = rej;
        return r;
    endfunction

    function automatic msr_pkg::result_t advance_motor(logic [1:0] f, logic [7:0] cmd,
                                                       logic fw);
        int unsigned duty;
        bit          rej;
        rej = 1'b0;
        case (f)
            msr_pkg::FUNC_TICK:
            begin
                if (motor_cur < motor_tgt)
                    motor_cur = (motor_cur + ramp_step_now >= motor_tgt) ? motor_tgt
                                                                         : motor_cur + ramp_step_now;
                else if (motor_cur > motor_tgt)
                    motor_cur = (motor_cur <= motor_tgt + ramp_step_now) ? motor_tgt
                                                                         : motor_cur - ramp_step_now;
                if (reversal_wait && motor_cur == 0 && motor_tgt == 0)
                begin
                    motor_fwd     = !motor_fwd;
                    motor_tgt     = motor_saved;
                    reversal_wait = 1'b0;
                end
            end
            msr_pkg::FUNC_SPEED:
            begin
                if (cmd > msr_pkg::SPEED_MAX)
                    rej = 1'b1;
                else if (reversal_wait)
                    motor_saved = cmd;
                else
                    motor_tgt = cmd;
            end
            msr_pkg::FUNC_DIR:
            begin
                if (!reversal_wait && fw != motor_fwd)
                begin
                    if (motor_cur == 0 && motor_tgt == 0)
                        motor_fwd = fw;
                    else
                    begin
                        motor_saved   = motor_tgt;
                        motor_tgt     = 0;
                        reversal_wait = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        duty = motor_cur * 102 / 10;
        return motor_status(motor_fwd ? duty : 0, motor_fwd ? 0 : duty, motor_cur,
                            motor_cur != motor_tgt, motor_fwd, rej);
    endfunction

    task automatic log_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
    endtask

    // called at a falling edge; valid stays high between back-to-back items
    task automatic send_command(input logic [1:0] f, input logic [7:0] cmd, input logic fw,
                                input bit known, input msr_pkg::result_t want);
        msr_pkg::result_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = f;
        s_tdata  = {7'b0, fw, cmd};
        do @(posedge clk); while (!s_tready);
        predicted = advance_motor(f, cmd, fw);
        expected_status_q.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_until_settled();
        s_tvalid = 1'b0;
        while (expected_status_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_ramp_step(input logic [6:0] v);
        wait_until_settled();
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        if (v <= msr_pkg::SPEED_MAX)
            ramp_step_now = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        msr_pkg::result_t got;
        msr_pkg::result_t want;
        got = msr_pkg::result_t'(m_tdata[29:0]);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_status_q.size() == 0)
                log_mismatch("result with nothing expected", m_tdata, 0);
            else
            begin
                want = expected_status_q.pop_front();
                if (got.duty_forward !== want.duty_forward)
                    log_mismatch("duty_forward", got.duty_forward, want.duty_forward);
                if (got.duty_reverse !== want.duty_reverse)
                    log_mismatch("duty_reverse", got.duty_reverse, want.duty_reverse);
                if (got.speed_now !== want.speed_now)
                    log_mismatch("speed_now", got.speed_now, want.speed_now);
                if (got.ramping !== want.ramping)
                    log_mismatch("ramping", got.ramping, want.ramping);
                if (got.going_forward !== want.going_forward)
                    log_mismatch("going_forward", got.going_forward, want.going_forward);
                if (got.rejected !== want.rejected)
                    log_mismatch("rejected", got.rejected, want.rejected);
            end
        end
    end

    initial
    begin
        int         sent;
        int         pick;
        logic [1:0] f;
        logic [7:0] cmd;
        logic       fw;
        logic [6:0] step;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        send_idle_pct  = 20;
        recv_idle_pct  = 20;
        ramp_step_now  = msr_pkg::STEP_RESET;
        motor_cur      = 0;
        motor_tgt      = 0;
        motor_saved    = 0;
        motor_fwd      = 1'b1;
        reversal_wait  = 1'b0;

        directed_rows = '{
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b1,
              motor_status(0, 0, 0, 0, 1, 0)},
            '{ROW_ITEM, msr_pkg::FUNC_SPEED, 8'd255, 1'b0, 1'b1,
              motor_status(0, 0, 0, 0, 1, 1)},
            '{ROW_ITEM, msr_pkg::FUNC_SPEED, 8'd101, 1'b1, 1'b1,
              motor_status(0, 0, 0, 0, 1, 1)},
            '{ROW_ITEM, msr_pkg::FUNC_SPEED, 8'd100, 1'b0, 1'b1,
              motor_status(0, 0, 0, 1, 1, 0)},
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b1,
              motor_status(51, 0, 5, 1, 1, 0)},
            '{ROW_ITEM, FUNC_UNUSED,         8'd255, 1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_DIR,   8'd0,   1'b1, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_DIR,   8'd0,   1'b0, 1'b0, NO_STATUS}, // starts reversal
            '{ROW_ITEM, msr_pkg::FUNC_SPEED, 8'd40,  1'b0, 1'b0, NO_STATUS}, // saved target
            '{ROW_ITEM, msr_pkg::FUNC_SPEED, 8'd150, 1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_DIR,   8'd0,   1'b1, 1'b0, NO_STATUS}, // ignored mid-reversal
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS}, // reaches zero, flips
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_SPEED, 8'd10,  1'b0, 1'b0, NO_STATUS}, // equals current speed
            '{ROW_ITEM, msr_pkg::FUNC_SPEED, 8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_DIR,   8'd0,   1'b1, 1'b0, NO_STATUS}, // still: immediate flip
            '{ROW_CFG,  msr_pkg::FUNC_TICK,  8'd100, 1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_SPEED, 8'd100, 1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b1,
              motor_status(1020, 0, 100, 0, 1, 0)},
            '{ROW_CFG,  msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_DIR,   8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS}, // zero step, no progress
            '{ROW_CFG,  msr_pkg::FUNC_TICK,  8'd127, 1'b0, 1'b0, NO_STATUS}, // out of range, kept 0
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_CFG,  msr_pkg::FUNC_TICK,  8'd100, 1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b0, NO_STATUS},
            '{ROW_ITEM, msr_pkg::FUNC_TICK,  8'd0,   1'b0, 1'b1,
              motor_status(0, 1020, 100, 0, 0, 0)}
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_ramp_step(directed_rows[i].value[6:0]);
            else
                send_command(directed_rows[i].f, directed_rows[i].value, directed_rows[i].fw,
                             directed_rows[i].known, directed_rows[i].want);
        end

        for (int p = 0; p < 15; p++)
        begin
            case (p)
                0:       step = 7'd100;
                1:       step = 7'd0;
                2:       step = 7'($urandom_range(101, 127));
                3:       step = 7'd1;
                default: step = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                            : 7'($urandom_range(1, 15));
            endcase
            write_ramp_step(step);
            send_idle_pct = (p >= 13) ? 0 : idle_levels[$urandom_range(0, 3)];
            recv_idle_pct = (p >= 13) ? 0 : idle_levels[$urandom_range(0, 3)];
            sent = 0;
            while (sent < 98)
            begin
                if (p == 7 && sent == 50)
                    wait_until_settled();
                pick = $urandom_range(0, 99);
                cmd  = 8'($urandom_range(0, 255));
                fw   = 1'($urandom_range(0, 1));
                if (pick < 50)
                    f = msr_pkg::FUNC_TICK;
                else if (pick < 75)
                begin
                    f = msr_pkg::FUNC_SPEED;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: cmd = 8'($urandom_range(0, 100));
                        6:                cmd = 8'(motor_cur);
                        7:                cmd = $urandom_range(0, 1) ? 8'd100 : 8'd0;
                        default: ;
                    endcase
                end
                else if (pick < 96)
                    f = msr_pkg::FUNC_DIR;
                else
                    f = FUNC_UNUSED;
                send_command(f, cmd, fw, 1'b0, NO_STATUS);
                if (f != FUNC_UNUSED)
                    sent++;
            end
        end

        s_tvalid = 1'b0;
        while (expected_status_q.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && expected_status_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
